// ===== sv/dtc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, reset values and register indexes for the differential
// thermostat controller. No dependencies.
package dtc_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned TempW    = 8;
  localparam int unsigned CntW     = 8;
  localparam int unsigned MenuW    = 10;
  localparam int unsigned CmpW     = 10;

  localparam logic [CntW-1:0]  CntMax  = '1;
  localparam logic [MenuW-1:0] MenuMax = '1;

  localparam logic [6:0]       OnDeltaRst      = 7'd10;
  localparam logic [6:0]       OffDeltaRst     = 7'd3;
  localparam logic [6:0]       LimitReleaseRst = 7'd5;
  localparam logic [7:0]       PressTicksRst   = 8'd5;
  localparam logic [7:0]       HoldTicksRst    = 8'd20;
  localparam logic [7:0]       RepeatTicksRst  = 8'd70;
  localparam logic [9:0]       MenuTicksRst    = 10'd500;
  localparam logic [6:0]       RepeatStepRst   = 7'd10;
  localparam logic [TempW-1:0] LimitRst        = 8'd60;

  typedef enum logic [CfgAddrW-1:0] {
    RegOnDelta      = 3'd0,
    RegOffDelta     = 3'd1,
    RegLimitRelease = 3'd2,
    RegPressTicks   = 3'd3,
    RegHoldTicks    = 3'd4,
    RegRepeatTicks  = 3'd5,
    RegMenuTicks    = 3'd6,
    RegRepeatStep   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [6:0] on_delta;
    logic [6:0] off_delta;
    logic [6:0] limit_release;
    logic [7:0] press_ticks;
    logic [7:0] hold_ticks;
    logic [7:0] repeat_ticks;
    logic [9:0] menu_ticks;
    logic [6:0] repeat_step;
  } cfg_t;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic            pressed;
    logic            held;
    logic [CntW-1:0] repeat_cnt;
  } btn_t;

  // Per-button result toward the shared menu and limit logic.
  typedef struct packed {
    logic             down;
    logic             open_menu;
    logic [TempW-1:0] limit_delta;
  } btn_evt_t;

endpackage

// ===== sv/dtc_button.sv =====
`timescale 1ns / 1ps
// One debounced button: press, hold and repeat counting, limit step request.
// Depends on dtc_pkg.
module dtc_button import dtc_pkg::*; (
  input  logic     down_i,
  input  logic     dir_minus_i,
  input  cfg_t     cfg_i,
  input  btn_t     btn_i,
  output btn_t     btn_o,
  output btn_evt_t evt_o
);

  logic [CntW-1:0]  cnt_inc;
  logic [CntW-1:0]  rep_inc;
  logic [TempW-1:0] step;
  logic [TempW-1:0] one;

  assign step = {1'b0, cfg_i.repeat_step};
  assign one  = TempW'(1);

  always_comb begin
    btn_o           = btn_i;
    evt_o.down      = down_i;
    evt_o.open_menu = 1'b0;
    evt_o.limit_delta = '0;
    cnt_inc = (btn_i.count == CntMax) ? btn_i.count : btn_i.count + CntW'(1);
    rep_inc = btn_i.repeat_cnt + CntW'(1);
    if (down_i) begin
      btn_o.count = cnt_inc;
      if (cnt_inc > cfg_i.press_ticks && !btn_i.pressed) begin
        btn_o.pressed   = 1'b1;
        evt_o.open_menu = 1'b1;
      end
      if (cnt_inc > cfg_i.hold_ticks) begin
        btn_o.held = 1'b1;
        if (rep_inc > cfg_i.repeat_ticks) begin
          evt_o.limit_delta = dir_minus_i ? (TempW'(0) - step) : step;
          btn_o.repeat_cnt  = '0;
        end else begin
          btn_o.repeat_cnt = rep_inc;
        end
      end
    end else begin
      if (btn_i.pressed && !btn_i.held) begin
        evt_o.limit_delta = dir_minus_i ? (TempW'(0) - one) : one;
      end
      btn_o = '0;
    end
  end

endmodule

// ===== sv/dtc_menu.sv =====
`timescale 1ns / 1ps
// Setpoint menu open flag and idle timeout counter.
// Depends on dtc_pkg.
module dtc_menu import dtc_pkg::*; (
  input  logic             any_down_i,
  input  logic             open_i,
  input  logic [MenuW-1:0] menu_ticks_i,
  input  logic             flag_i,
  input  logic [MenuW-1:0] count_i,
  output logic             flag_o,
  output logic [MenuW-1:0] count_o
);

  logic             flag_b;
  logic [MenuW-1:0] count_b;
  logic [MenuW-1:0] count_t;

  always_comb begin
    flag_b  = flag_i | open_i;
    count_b = any_down_i ? '0 : count_i;
    count_t = (flag_b && count_b != MenuMax) ? count_b + MenuW'(1) : count_b;
    if (count_t > menu_ticks_i) begin
      flag_o  = 1'b0;
      count_o = '0;
    end else begin
      flag_o  = flag_b;
      count_o = count_t;
    end
  end

endmodule

// ===== sv/dtc_relay.sv =====
`timescale 1ns / 1ps
// Differential relay rules with high-limit lockout on the store.
// Depends on dtc_pkg.
module dtc_relay import dtc_pkg::*; (
  input  logic signed [TempW-1:0] source_i,
  input  logic signed [TempW-1:0] store_i,
  input  logic        [TempW-1:0] limit_i,
  input  cfg_t                    cfg_i,
  input  logic                    relay_i,
  input  logic                    enabled_i,
  output logic                    relay_o,
  output logic                    enabled_o
);

  logic signed [CmpW-1:0] src_w;
  logic signed [CmpW-1:0] store_w;
  logic signed [CmpW-1:0] lim_w;
  logic signed [CmpW-1:0] on_thr;
  logic signed [CmpW-1:0] off_thr;
  logic signed [CmpW-1:0] rel_thr;

  assign src_w   = CmpW'(source_i);
  assign store_w = CmpW'(store_i);
  assign lim_w   = CmpW'($signed(limit_i));
  assign on_thr  = store_w + $signed({3'b000, cfg_i.on_delta});
  assign off_thr = store_w + $signed({3'b000, cfg_i.off_delta});
  assign rel_thr = lim_w - $signed({3'b000, cfg_i.limit_release});

  always_comb begin
    relay_o   = relay_i;
    enabled_o = enabled_i;
    if (src_w > on_thr && enabled_o && !relay_o) begin
      relay_o = 1'b1;
    end
    if (src_w < off_thr && enabled_o) begin
      relay_o = 1'b0;
    end
    if (store_w > lim_w && enabled_o) begin
      relay_o   = 1'b0;
      enabled_o = 1'b0;
    end
    if (store_w < rel_thr) begin
      enabled_o = 1'b1;
    end
  end

endmodule

// ===== sv/differential_thermostat_controller.sv =====
`timescale 1ns / 1ps
// An accepted transaction passes from the input register into the result register.
// Throughput: one transaction per cycle while out_ready_i does not stall; input and result
// registers (the result register is the controller state) form two stages with stall propagation.
// Reset: asynchronous, active low; config and state registers return to
// defaults, limit 60, relay off, lockout clear, menu closed, both buttons idle.
module differential_thermostat_controller import dtc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgAddrW-1:0]     cfg_addr_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    plus_down_i,
  input  logic                    minus_down_i,
  input  logic signed [TempW-1:0] source_temp_i,
  input  logic signed [TempW-1:0] store_temp_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    relay_on_o,
  output logic                    locked_out_o,
  output logic signed [TempW-1:0] store_limit_o,
  output logic                    menu_open_o
);

  cfg_t cfg_q;

  logic                    in_valid_q;
  logic                    plus_q, minus_q;
  logic signed [TempW-1:0] source_q, store_q;
  logic                    out_valid_q;
  logic                    s1_fire;
  logic                    in_fire;

  btn_t             plus_btn_q, plus_btn_d, minus_btn_q, minus_btn_d;
  btn_evt_t         plus_evt, minus_evt;
  logic [MenuW-1:0] menu_cnt_q, menu_cnt_d;
  logic             menu_flag_q, menu_flag_d;
  logic [TempW-1:0] limit_q, limit_d;
  logic             relay_q, relay_d;
  logic             enabled_q, enabled_d;

  assign s1_fire    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{on_delta: OnDeltaRst, off_delta: OffDeltaRst,
                 limit_release: LimitReleaseRst, press_ticks: PressTicksRst,
                 hold_ticks: HoldTicksRst, repeat_ticks: RepeatTicksRst,
                 menu_ticks: MenuTicksRst, repeat_step: RepeatStepRst};
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        RegOnDelta:      cfg_q.on_delta      <= cfg_wdata_i[6:0];
        RegOffDelta:     cfg_q.off_delta     <= cfg_wdata_i[6:0];
        RegLimitRelease: cfg_q.limit_release <= cfg_wdata_i[6:0];
        RegPressTicks:   cfg_q.press_ticks   <= cfg_wdata_i[7:0];
        RegHoldTicks:    cfg_q.hold_ticks    <= cfg_wdata_i[7:0];
        RegRepeatTicks:  cfg_q.repeat_ticks  <= cfg_wdata_i[7:0];
        RegMenuTicks:    cfg_q.menu_ticks    <= cfg_wdata_i[9:0];
        RegRepeatStep:   cfg_q.repeat_step   <= cfg_wdata_i[6:0];
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      plus_q   <= plus_down_i;
      minus_q  <= minus_down_i;
      source_q <= source_temp_i;
      store_q  <= store_temp_i;
    end
  end

  dtc_button u_plus (
    .down_i      (plus_q),
    .dir_minus_i (1'b0),
    .cfg_i       (cfg_q),
    .btn_i       (plus_btn_q),
    .btn_o       (plus_btn_d),
    .evt_o       (plus_evt)
  );

  dtc_button u_minus (
    .down_i      (minus_q),
    .dir_minus_i (1'b1),
    .cfg_i       (cfg_q),
    .btn_i       (minus_btn_q),
    .btn_o       (minus_btn_d),
    .evt_o       (minus_evt)
  );

  assign limit_d = limit_q + plus_evt.limit_delta + minus_evt.limit_delta;

  dtc_menu u_menu (
    .any_down_i   (plus_evt.down | minus_evt.down),
    .open_i       (plus_evt.open_menu | minus_evt.open_menu),
    .menu_ticks_i (cfg_q.menu_ticks),
    .flag_i       (menu_flag_q),
    .count_i      (menu_cnt_q),
    .flag_o       (menu_flag_d),
    .count_o      (menu_cnt_d)
  );

  dtc_relay u_relay (
    .source_i  (source_q),
    .store_i   (store_q),
    .limit_i   (limit_d),
    .cfg_i     (cfg_q),
    .relay_i   (relay_q),
    .enabled_i (enabled_q),
    .relay_o   (relay_d),
    .enabled_o (enabled_d)
  );

  // Result stage: controller state doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      plus_btn_q  <= '0;
      minus_btn_q <= '0;
      menu_cnt_q  <= '0;
      menu_flag_q <= 1'b0;
      limit_q     <= LimitRst;
      relay_q     <= 1'b0;
      enabled_q   <= 1'b1;
    end else begin
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        plus_btn_q  <= plus_btn_d;
        minus_btn_q <= minus_btn_d;
        menu_cnt_q  <= menu_cnt_d;
        menu_flag_q <= menu_flag_d;
        limit_q     <= limit_d;
        relay_q     <= relay_d;
        enabled_q   <= enabled_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign relay_on_o    = relay_q;
  assign locked_out_o  = !enabled_q;
  assign store_limit_o = $signed(limit_q);
  assign menu_open_o   = menu_flag_q;

  a_lock_relay_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !enabled_q |-> !relay_q)
    else $error("relay on during lockout");

  a_menu_cnt_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (menu_cnt_q != '0) |-> menu_flag_q)
    else $error("menu counting while closed");

  a_stage_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_q)
    else $error("advanced transaction produced no result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(limit_q) && $stable(relay_q))
    else $error("state moved while result stalled");

  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with free stages");

endmodule
